FILE: rtl/ees_pkg.sv
package ees_pkg;

   // request function codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_DATA  = 2'd2;
   localparam logic [1:0] FUNC_REPLY = 2'd3;

   // bus command codes
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_SEND    = 3'd3;
   localparam logic [2:0] CMD_RD_ACK  = 3'd4;
   localparam logic [2:0] CMD_RD_NACK = 3'd5;

   // register indexes
   localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_ADDR_BYTES     = 2'd1;
   localparam logic [1:0] REG_PAGE_LOG2      = 2'd2;
   localparam logic [1:0] REG_POLL_LIMIT     = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 10;

   // register reset values
   localparam logic [7:0] DEVICE_ADDRESS_RST = 8'hA0;
   localparam logic [1:0] ADDR_BYTES_RST     = 2'd1;
   localparam logic [2:0] PAGE_LOG2_RST      = 3'd3;
   localparam logic [9:0] POLL_LIMIT_RST     = 10'd1000;

   // depth of the run queue between front and back
   localparam int unsigned RUN_QUEUE_DEPTH = 4;

   // items one request can produce
   localparam int unsigned RUN_ITEMS = 3;

   typedef struct packed {
      logic [7:0] device_address;
      logic [1:0] address_byte_count;
      logic [2:0] page_size_log2;
      logic [9:0] poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] bus_cmd;
      logic [7:0] bus_byte;
      logic [7:0] read_data;
      logic       read_valid;
      logic       data_request;
      logic       done_res;
      logic       success;
   } item_type;

   // one request's run of result items, item 0 goes out first
   typedef struct packed {
      logic [1:0]                   count;
      item_type [RUN_ITEMS-1:0]     items;
   } run_type;

   function automatic item_type mk_item(logic [2:0] cmd, logic [7:0] bus_byte);
      item_type it;
      it          = '0;
      it.bus_cmd  = cmd;
      it.bus_byte = bus_byte;
      return it;
   endfunction

   function automatic item_type mk_finish(logic ok);
      item_type it;
      it          = '0;
      it.bus_cmd  = CMD_STOP;
      it.done_res = 1'b1;
      it.success  = ok;
      return it;
   endfunction

endpackage

FILE: rtl/ees_front.sv
module ees_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        func,
   input  logic [15:0]       mem_address,
   input  logic [15:0]       byte_count,
   input  logic [7:0]        write_data,
   input  logic              bus_nack,
   input  logic [7:0]        bus_rdata,
   input  ees_pkg::cfg_type  cfg,
   output logic              run_push,
   output ees_pkg::run_type  run
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RD_DEVW,
      PH_RD_ADDR,
      PH_RD_DEVR,
      PH_RD_DATA,
      PH_WR_POLL,
      PH_WR_ADDR,
      PH_WR_NEED,
      PH_WR_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [9:0]  poll_ff, poll_in;
   logic        abi_ff, abi_in;

   logic [15:0]      page_mask;
   logic [15:0]      addr_inc;
   logic [15:0]      left_dec;
   logic [9:0]       poll_inc;
   ees_pkg::item_type first_addr;
   logic             first_abi;
   ees_pkg::item_type want_item;
   ees_pkg::item_type rd_item;

   // shared pieces of the transitions
   always_comb begin
      page_mask = ~(16'hFFFF << cfg.page_size_log2);
      addr_inc  = addr_ff + 16'd1;
      left_dec  = left_ff - 16'd1;
      poll_inc  = poll_ff + 10'd1;
      first_abi = ~cfg.address_byte_count[1];
      if (cfg.address_byte_count[1]) begin
         first_addr = ees_pkg::mk_item(ees_pkg::CMD_SEND, addr_ff[15:8]);
      end else begin
         first_addr = ees_pkg::mk_item(ees_pkg::CMD_SEND, addr_ff[7:0]);
      end
      want_item              = ees_pkg::mk_item(ees_pkg::CMD_NONE, 8'd0);
      want_item.data_request = 1'b1;
      rd_item                = ees_pkg::mk_item(ees_pkg::CMD_NONE, 8'd0);
      rd_item.read_data      = bus_rdata;
      rd_item.read_valid     = 1'b1;
   end

   // transaction sequencing, one request per cycle while accept is high
   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      poll_in  = poll_ff;
      abi_in   = abi_ff;
      run      = '0;
      if (accept) begin
         case (func)
            ees_pkg::FUNC_READ: begin
               if (phase_ff == PH_IDLE) begin
                  addr_in      = mem_address;
                  left_in      = byte_count;
                  phase_in     = PH_RD_DEVW;
                  run.count    = 2'd2;
                  run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_START, 8'd0);
                  run.items[1] = ees_pkg::mk_item(ees_pkg::CMD_SEND, cfg.device_address);
               end
            end
            ees_pkg::FUNC_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  addr_in = mem_address;
                  left_in = byte_count;
                  if (byte_count == 16'd0) begin
                     run.count    = 2'd1;
                     run.items[0] = ees_pkg::mk_finish(1'b1);
                  end else begin
                     poll_in      = '0;
                     phase_in     = PH_WR_POLL;
                     run.count    = 2'd3;
                     run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_STOP, 8'd0);
                     run.items[1] = ees_pkg::mk_item(ees_pkg::CMD_START, 8'd0);
                     run.items[2] = ees_pkg::mk_item(ees_pkg::CMD_SEND, cfg.device_address);
                  end
               end
            end
            ees_pkg::FUNC_DATA: begin
               if (phase_ff == PH_WR_NEED) begin
                  phase_in     = PH_WR_DATA;
                  run.count    = 2'd1;
                  run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_SEND, write_data);
               end
            end
            default: begin
               case (phase_ff)
                  PH_RD_DEVW: begin
                     run.count = 2'd1;
                     if (bus_nack) begin
                        phase_in     = PH_IDLE;
                        run.items[0] = ees_pkg::mk_finish(1'b0);
                     end else begin
                        phase_in     = PH_RD_ADDR;
                        abi_in       = first_abi;
                        run.items[0] = first_addr;
                     end
                  end
                  PH_RD_ADDR: begin
                     if (bus_nack) begin
                        phase_in     = PH_IDLE;
                        run.count    = 2'd1;
                        run.items[0] = ees_pkg::mk_finish(1'b0);
                     end else if (!abi_ff) begin
                        abi_in       = 1'b1;
                        run.count    = 2'd1;
                        run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_SEND, addr_ff[7:0]);
                     end else begin
                        phase_in     = PH_RD_DEVR;
                        run.count    = 2'd2;
                        run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_START, 8'd0);
                        run.items[1] = ees_pkg::mk_item(ees_pkg::CMD_SEND,
                                                        cfg.device_address | 8'd1);
                     end
                  end
                  PH_RD_DEVR: begin
                     run.count = 2'd1;
                     if (bus_nack) begin
                        phase_in     = PH_IDLE;
                        run.items[0] = ees_pkg::mk_finish(1'b0);
                     end else if (left_ff == 16'd0) begin
                        phase_in     = PH_IDLE;
                        run.items[0] = ees_pkg::mk_finish(1'b1);
                     end else begin
                        phase_in     = PH_RD_DATA;
                        run.items[0] = ees_pkg::mk_item((left_ff == 16'd1) ?
                           ees_pkg::CMD_RD_NACK : ees_pkg::CMD_RD_ACK, 8'd0);
                     end
                  end
                  PH_RD_DATA: begin
                     left_in      = left_dec;
                     addr_in      = addr_inc;
                     run.count    = 2'd2;
                     run.items[0] = rd_item;
                     if (left_dec == 16'd0) begin
                        phase_in     = PH_IDLE;
                        run.items[1] = ees_pkg::mk_finish(1'b1);
                     end else begin
                        run.items[1] = ees_pkg::mk_item((left_dec == 16'd1) ?
                           ees_pkg::CMD_RD_NACK : ees_pkg::CMD_RD_ACK, 8'd0);
                     end
                  end
                  PH_WR_POLL: begin
                     if (bus_nack) begin
                        poll_in = poll_inc;
                        if (poll_inc >= cfg.poll_limit) begin
                           phase_in     = PH_IDLE;
                           run.count    = 2'd1;
                           run.items[0] = ees_pkg::mk_finish(1'b0);
                        end else begin
                           run.count    = 2'd2;
                           run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_START, 8'd0);
                           run.items[1] = ees_pkg::mk_item(ees_pkg::CMD_SEND,
                                                           cfg.device_address);
                        end
                     end else begin
                        phase_in     = PH_WR_ADDR;
                        abi_in       = first_abi;
                        run.count    = 2'd1;
                        run.items[0] = first_addr;
                     end
                  end
                  PH_WR_ADDR: begin
                     run.count = 2'd1;
                     if (bus_nack) begin
                        phase_in     = PH_IDLE;
                        run.items[0] = ees_pkg::mk_finish(1'b0);
                     end else if (!abi_ff) begin
                        abi_in       = 1'b1;
                        run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_SEND, addr_ff[7:0]);
                     end else begin
                        phase_in     = PH_WR_NEED;
                        run.items[0] = want_item;
                     end
                  end
                  PH_WR_DATA: begin
                     if (bus_nack) begin
                        phase_in     = PH_IDLE;
                        run.count    = 2'd1;
                        run.items[0] = ees_pkg::mk_finish(1'b0);
                     end else begin
                        addr_in = addr_inc;
                        left_in = left_dec;
                        if (left_dec == 16'd0) begin
                           phase_in     = PH_IDLE;
                           run.count    = 2'd1;
                           run.items[0] = ees_pkg::mk_finish(1'b1);
                        end else if ((addr_inc & page_mask) == 16'd0) begin
                           // page boundary: close and reopen with polling
                           poll_in      = '0;
                           phase_in     = PH_WR_POLL;
                           run.count    = 2'd3;
                           run.items[0] = ees_pkg::mk_item(ees_pkg::CMD_STOP, 8'd0);
                           run.items[1] = ees_pkg::mk_item(ees_pkg::CMD_START, 8'd0);
                           run.items[2] = ees_pkg::mk_item(ees_pkg::CMD_SEND,
                                                           cfg.device_address);
                        end else begin
                           phase_in     = PH_WR_NEED;
                           run.count    = 2'd1;
                           run.items[0] = want_item;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         endcase
      end
      run_push = (run.count != 2'd0);
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         addr_ff  <= '0;
         left_ff  <= '0;
         poll_ff  <= '0;
         abi_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         poll_ff  <= poll_in;
         abi_ff   <= abi_in;
      end
   end

endmodule

FILE: rtl/ees_queue.sv
module ees_queue #(
   parameter int unsigned DEPTH = ees_pkg::RUN_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  ees_pkg::run_type push_run,
   output logic             q_full,
   input  logic             pop_en,
   output logic             q_valid,
   output ees_pkg::run_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   ees_pkg::run_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      q_full    = (cnt_ff == FULL_CNT);
      q_valid   = (cnt_ff != '0);
      head      = slot_ff[rd_ptr_ff];
      do_push   = push_en && !q_full;
      do_pop    = pop_en && q_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // run storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

FILE: rtl/ees_back.sv
module ees_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ees_pkg::run_type  head,
   output logic              q_pop,
   input  logic              rsp_take,
   output logic              rsp_valid,
   output ees_pkg::item_type rsp_item,
   output logic              rsp_last
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   ees_pkg::item_type item_ff, item_in;
   logic              last_ff, last_in;
   logic              load;
   logic              at_end;

   // unroll the head run one item per cycle into the output register, while that register is empty or being taken
   always_comb begin
      load     = q_valid && (!valid_ff || rsp_take);
      at_end   = (idx_ff == head.count - 2'd1);
      q_pop    = load && at_end;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      item_in  = item_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = head.items[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: rtl/i2c_eeprom_transaction_sequencer.sv
// Turns 24xx serial EEPROM read and write requests, written data bytes and bus
// replies into a stream of I2C primitives (start, stop, send byte, read with ACK
// or NACK) plus read data, data requests and a done/success flag on the final
// stop. A request is taken whenever the run queue between the sequencer and the
// output stage has room; its results pass a queue slot and the output register.
// Each request yields zero to three results, which leave one per cycle through
// the output register while taken: requests with at most one result go back to
// back at one per cycle, while runs of two or three results fill the run queue
// (default four runs) and hold the request rate to the result rate. The user
// must write configuration registers through the csr port only while no
// transaction is open and all results have been taken, unchecked by the block.
module i2c_eeprom_transaction_sequencer #(
   parameter int unsigned RUN_QUEUE_DEPTH = ees_pkg::RUN_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [1:0]                      req_func,
   input  logic [15:0]                     req_mem_address,
   input  logic [15:0]                     req_byte_count,
   input  logic [7:0]                      req_write_data,
   input  logic                            req_bus_nack,
   input  logic [7:0]                      req_bus_rdata,
   output logic                            empty,
   input  logic                            pop,
   output logic [2:0]                      rsp_bus_cmd,
   output logic [7:0]                      rsp_bus_byte,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_read_valid,
   output logic                            rsp_data_request,
   output logic                            rsp_done_res,
   output logic                            rsp_success,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ees_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ees_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ees_pkg::cfg_type  cfg_ff;
   ees_pkg::run_type  run;
   ees_pkg::run_type  head;
   ees_pkg::item_type rsp_item;
   logic              accept;
   logic              run_push;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   logic              rsp_valid;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address     <= ees_pkg::DEVICE_ADDRESS_RST;
         cfg_ff.address_byte_count <= ees_pkg::ADDR_BYTES_RST;
         cfg_ff.page_size_log2     <= ees_pkg::PAGE_LOG2_RST;
         cfg_ff.poll_limit         <= ees_pkg::POLL_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ees_pkg::REG_DEVICE_ADDRESS: cfg_ff.device_address     <= csr_wdata[7:0];
            ees_pkg::REG_ADDR_BYTES:     cfg_ff.address_byte_count <= csr_wdata[1:0];
            ees_pkg::REG_PAGE_LOG2:      cfg_ff.page_size_log2     <= csr_wdata[2:0];
            ees_pkg::REG_POLL_LIMIT:     cfg_ff.poll_limit         <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // request side
   assign full   = q_full;
   assign accept = push && !q_full;

   ees_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .mem_address (req_mem_address),
      .byte_count  (req_byte_count),
      .write_data  (req_write_data),
      .bus_nack    (req_bus_nack),
      .bus_rdata   (req_bus_rdata),
      .cfg         (cfg_ff),
      .run_push    (run_push),
      .run         (run)
   );

   ees_queue #(
      .DEPTH (RUN_QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (run_push),
      .push_run (run),
      .q_full   (q_full),
      .pop_en   (q_pop),
      .q_valid  (q_valid),
      .head     (head)
   );

   ees_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .q_pop     (q_pop),
      .rsp_take  (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_last  (rsp_last)
   );

   // response side
   assign empty            = !rsp_valid;
   assign rsp_bus_cmd      = rsp_item.bus_cmd;
   assign rsp_bus_byte     = rsp_item.bus_byte;
   assign rsp_read_data    = rsp_item.read_data;
   assign rsp_read_valid   = rsp_item.read_valid;
   assign rsp_data_request = rsp_item.data_request;
   assign rsp_done_res     = rsp_item.done_res;
   assign rsp_success      = rsp_item.success;

endmodule

FILE: rtl/ees_checker.sv
module ees_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [2:0] rsp_bus_cmd,
   input logic [7:0] rsp_bus_byte,
   input logic       rsp_read_valid,
   input logic       rsp_done_res,
   input logic       rsp_success,
   input logic       rsp_last
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not empty after reset");

   // a waiting response holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_bus_cmd) && $stable(rsp_bus_byte))
      else $error("waiting response changed");

   // a transaction ends only on a stop that closes its run
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_done_res |-> rsp_bus_cmd == ees_pkg::CMD_STOP && rsp_last)
      else $error("done without final stop");

   // received data is always followed by another item of the same run
   a_read_not_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_read_valid |-> !rsp_last && rsp_bus_cmd == ees_pkg::CMD_NONE)
      else $error("read data closes a run");

   // success is only reported with done
   a_success_done: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_success |-> rsp_done_res)
      else $error("success without done");

endmodule

bind i2c_eeprom_transaction_sequencer ees_checker u_ees_checker (.*);
